// ----- hdl/sbus_channel_decode_calibrate_defines.svh -----
// ---------------------------------------------------------------------------
// sbus channel decoder assertion macros
// shared property forms used by the port checker
// ---------------------------------------------------------------------------
`ifndef SBUS_CHANNEL_DECODE_CALIBRATE_DEFINES_SVH
`define SBUS_CHANNEL_DECODE_CALIBRATE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SBCD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbcd check failed");

// next-cycle implication, clocked on i_clk, off during reset
`define SBCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbcd check failed");

`endif

// ----- hdl/sbcd_pkg.sv -----
// ---------------------------------------------------------------------------
// sbcd_pkg
// constants and controller/datapath interface types for the sbus decoder
// ---------------------------------------------------------------------------
package sbcd_pkg;

    localparam int FRAME_BYTES = 25;
    localparam int NUM_CH      = 8;
    localparam int CNT_W       = 5;
    localparam int CH_W        = 11;
    localparam int OUT_W       = 12;
    localparam int IDX_W       = 3;
    localparam int QUO_W       = 24;
    localparam int STEP_W      = 5;

    localparam logic [CNT_W-1:0] COUNT_SAT   = CNT_W'(FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0] COUNT_FULL  = CNT_W'(FRAME_BYTES);
    localparam logic [CH_W-1:0]  LOW_RESET   = 11'd353;
    localparam logic [CH_W-1:0]  HIGH_RESET  = 11'd1697;
    localparam logic [OUT_W-1:0] OUT_MIN_RST = 12'd1000;
    localparam logic [OUT_W-1:0] OUT_MAX_RST = 12'd2000;
    localparam logic [CH_W-1:0]  THR_RST     = 11'd200;

    // request kinds
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_CAL  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_OUT_MIN = 2'd0;
    localparam logic [1:0] REG_OUT_MAX = 2'd1;
    localparam logic [1:0] REG_THR     = 2'd2;
    localparam logic [1:0] REG_SAVE    = 2'd3;

    typedef struct packed {
        logic             take_req;
        logic             mul;
        logic             sum;
        logic             div_step;
        logic             load_out;
        logic [IDX_W-1:0] ch_sel;
    } t_cmd;

    typedef struct packed {
        logic connected;
        logic calibrating;
    } t_sts;

endpackage

// ----- hdl/sbcd_datapath.sv -----
// ---------------------------------------------------------------------------
// sbcd_datapath
// frame buffer, channel state, limits, multiply and bit-serial divide
// ---------------------------------------------------------------------------
module sbcd_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sbcd_pkg::t_cmd              i_cmd,
    output sbcd_pkg::t_sts              o_sts,
    input  logic [1:0]                  i_req_type,
    input  logic [7:0]                  i_rx_byte,
    input  logic                        i_frame_end,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [sbcd_pkg::OUT_W-1:0]  i_cfg_data,
    output logic [sbcd_pkg::OUT_W-1:0]  o_value
);

    logic [7:0]                  r_buf [sbcd_pkg::FRAME_BYTES];
    logic [sbcd_pkg::CNT_W-1:0]  r_count;
    logic [sbcd_pkg::CH_W-1:0]   r_val  [sbcd_pkg::NUM_CH];
    logic [sbcd_pkg::CH_W-1:0]   r_lo   [sbcd_pkg::NUM_CH];
    logic [sbcd_pkg::CH_W-1:0]   r_hi   [sbcd_pkg::NUM_CH];
    logic                        r_conn;
    logic                        r_cal;
    logic [sbcd_pkg::OUT_W-1:0]  r_out_min;
    logic [sbcd_pkg::OUT_W-1:0]  r_out_max;
    logic [sbcd_pkg::CH_W-1:0]   r_thr;
    logic                        r_save;

    logic [22:0]                 r_p1;
    logic signed [24:0]          r_p2;
    logic [sbcd_pkg::CH_W-1:0]   r_d;
    logic                        r_inval;
    logic                        r_zero;
    logic [sbcd_pkg::QUO_W-1:0]  r_quo;
    logic [sbcd_pkg::CH_W-1:0]   r_rem;
    logic [sbcd_pkg::OUT_W-1:0]  r_value;

    logic [8*sbcd_pkg::FRAME_BYTES-1:0] w_flat;
    logic [sbcd_pkg::CH_W-1:0]   w_unp [sbcd_pkg::NUM_CH];
    logic [sbcd_pkg::CNT_W-1:0]  n_count;
    logic [sbcd_pkg::CH_W-1:0]   w_v, w_lo, w_hi;
    logic signed [11:0]          w_dv;
    logic signed [12:0]          w_rg;
    logic signed [25:0]          w_t;
    logic [11:0]                 w_rsh;
    logic                        w_ge;
    logic [sbcd_pkg::OUT_W-1:0]  w_sat, w_fin;

    // flatten buffer, byte 0 lowest
    always_comb begin
        for (int i = 0; i < sbcd_pkg::FRAME_BYTES; i++) begin
            w_flat[8*i +: 8] = r_buf[i];
        end
        for (int k = 0; k < sbcd_pkg::NUM_CH; k++) begin
            w_unp[k] = w_flat[8 + sbcd_pkg::CH_W*k +: sbcd_pkg::CH_W];
        end
    end

    always_comb begin
        if (r_count < sbcd_pkg::COUNT_FULL) begin
            n_count = r_count + 1'b1;
        end else begin
            n_count = sbcd_pkg::COUNT_SAT;
        end
    end

    assign w_v  = r_val[i_cmd.ch_sel];
    assign w_lo = r_lo[i_cmd.ch_sel];
    assign w_hi = r_hi[i_cmd.ch_sel];
    assign w_dv = $signed({1'b0, w_v}) - $signed({1'b0, w_lo});
    assign w_rg = $signed({1'b0, r_out_max}) - $signed({1'b0, r_out_min});
    assign w_t  = $signed({3'b000, r_p1}) + $signed({r_p2[24], r_p2});

    assign w_rsh = {r_rem, r_quo[sbcd_pkg::QUO_W-1]};
    assign w_ge  = w_rsh >= {1'b0, r_d};

    // upper clamp first, lower clamp last
    assign w_sat = (r_quo > {12'd0, r_out_max}) ? r_out_max : r_quo[sbcd_pkg::OUT_W-1:0];
    assign w_fin = (r_zero || (w_sat < r_out_min)) ? r_out_min : w_sat;

    // buffer bytes, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req && (i_req_type == sbcd_pkg::REQ_BYTE) &&
            (r_count < sbcd_pkg::COUNT_FULL)) begin
            r_buf[r_count] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_conn    <= 1'b0;
            r_cal     <= 1'b0;
            r_out_min <= sbcd_pkg::OUT_MIN_RST;
            r_out_max <= sbcd_pkg::OUT_MAX_RST;
            r_thr     <= sbcd_pkg::THR_RST;
            r_save    <= 1'b0;
            for (int k = 0; k < sbcd_pkg::NUM_CH; k++) begin
                r_val[k] <= '0;
                r_lo[k]  <= sbcd_pkg::LOW_RESET;
                r_hi[k]  <= sbcd_pkg::HIGH_RESET;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sbcd_pkg::REG_OUT_MIN: r_out_min <= i_cfg_data;
                    sbcd_pkg::REG_OUT_MAX: r_out_max <= i_cfg_data;
                    sbcd_pkg::REG_THR:     r_thr     <= i_cfg_data[sbcd_pkg::CH_W-1:0];
                    sbcd_pkg::REG_SAVE:    r_save    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.take_req) begin
                unique case (i_req_type)
                    sbcd_pkg::REQ_BYTE: begin
                        if (i_frame_end) begin
                            r_count <= '0;
                            if (n_count == sbcd_pkg::COUNT_FULL) begin
                                for (int k = 0; k < sbcd_pkg::NUM_CH; k++) begin
                                    r_val[k] <= w_unp[k];
                                end
                                r_conn <= (w_unp[0] > r_thr) && (w_unp[1] > r_thr);
                            end
                        end else begin
                            r_count <= n_count;
                        end
                    end
                    sbcd_pkg::REQ_CAL: r_cal <= 1'b1;
                    sbcd_pkg::REQ_TICK: begin
                        if (r_conn && r_cal) begin
                            for (int k = 0; k < sbcd_pkg::NUM_CH; k++) begin
                                if (r_val[k] < r_lo[k]) r_lo[k] <= r_val[k];
                                if (r_val[k] > r_hi[k]) r_hi[k] <= r_val[k];
                            end
                            if (r_save) r_cal <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // scaling arithmetic, payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_d     <= w_hi - w_lo;
            r_inval <= w_hi <= w_lo;
            r_p1    <= r_out_min * (w_hi - w_lo);
            r_p2    <= w_dv * w_rg;
        end
        if (i_cmd.sum) begin
            r_zero <= r_inval || w_t[25];
            r_quo  <= w_t[sbcd_pkg::QUO_W-1:0];
            r_rem  <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[sbcd_pkg::QUO_W-2:0], w_ge};
            r_rem <= w_ge ? w_rsh[sbcd_pkg::CH_W-1:0] - r_d : w_rsh[sbcd_pkg::CH_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_value <= w_fin;
        end
    end

    assign o_sts.connected   = r_conn;
    assign o_sts.calibrating = r_cal;
    assign o_value           = r_value;

endmodule

// ----- hdl/sbcd_ctrl.sv -----
// ---------------------------------------------------------------------------
// sbcd_ctrl
// sequences request intake and the per-channel scale and divide steps
// ---------------------------------------------------------------------------
module sbcd_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic [1:0]                  i_req_type,
    output logic                        o_req_ready,
    input  sbcd_pkg::t_sts              i_sts,
    output sbcd_pkg::t_cmd              o_cmd,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic                        o_res_last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_LOAD = 3'd4;
    localparam logic [2:0] ST_SEND = 3'd5;

    localparam logic [sbcd_pkg::IDX_W-1:0]  LAST_CH   = sbcd_pkg::IDX_W'(sbcd_pkg::NUM_CH - 1);
    localparam logic [sbcd_pkg::STEP_W-1:0] LAST_STEP = sbcd_pkg::STEP_W'(sbcd_pkg::QUO_W - 1);

    logic [2:0]                    r_state, n_state;
    logic [sbcd_pkg::IDX_W-1:0]    r_ch, n_ch;
    logic [sbcd_pkg::STEP_W-1:0]   r_step, n_step;
    logic                          w_take;

    assign w_take = i_req_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take && (i_req_type == sbcd_pkg::REQ_TICK) &&
                    i_sts.connected && !i_sts.calibrating) begin
                    n_state = ST_MUL;
                    n_ch    = '0;
                end
            end
            ST_MUL:  n_state = ST_SUM;
            ST_SUM: begin
                n_state = ST_DIV;
                n_step  = '0;
            end
            ST_DIV: begin
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) n_state = ST_LOAD;
            end
            ST_LOAD: n_state = ST_SEND;
            ST_SEND: begin
                if (i_res_ready) begin
                    if (r_ch == LAST_CH) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_MUL;
                        n_ch    = r_ch + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ch    <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_step  <= n_step;
        end
    end

    assign o_req_ready     = r_state == ST_IDLE;
    assign o_cmd.take_req  = w_take;
    assign o_cmd.mul       = r_state == ST_MUL;
    assign o_cmd.sum       = r_state == ST_SUM;
    assign o_cmd.div_step  = r_state == ST_DIV;
    assign o_cmd.load_out  = r_state == ST_LOAD;
    assign o_cmd.ch_sel    = r_ch;
    assign o_res_valid     = r_state == ST_SEND;
    assign o_res_last      = r_ch == LAST_CH;

endmodule

// ----- hdl/sbus_channel_decode_calibrate.sv -----
// ---------------------------------------------------------------------------
// sbus_channel_decode_calibrate
// sbus frame decoder with per-channel calibration and linear output scaling
// ---------------------------------------------------------------------------
// One request is taken at a time. A byte, start-calibration or calibration
// tick request finishes in the cycle it is accepted, so the controller stays
// idle and ready for the next request. A scaling tick produces eight results,
// one per channel; each channel passes through multiply, sum, a 24-step
// bit-serial restoring divide, clamp and send, and each result waits for
// i_m_axis_tready, so a tick holds off the next request until its last
// result is taken. The divider is shared and gives one quotient bit per cycle.
// Configuration writes are always accepted (o_cfg_ready is tied high).
module sbus_channel_decode_calibrate (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] req_type
    input  logic        i_s_axis_tlast,   // frame_end
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [11:0] scaled_value, [15:12] zero
    output logic [2:0]  o_m_axis_tuser,   // [2:0] channel_index
    output logic        o_m_axis_tlast,   // last
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,      // 0 out_min, 1 out_max, 2 threshold, 3 save
    input  logic [11:0] i_cfg_data
);

    sbcd_pkg::t_cmd                 w_cmd;
    sbcd_pkg::t_sts                 w_sts;
    logic [sbcd_pkg::OUT_W-1:0]     w_value;

    // controller: request intake and channel sequencing
    sbcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .i_req_type  (i_s_axis_tuser),
        .o_req_ready (o_s_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res_last  (o_m_axis_tlast)
    );

    // datapath: buffer, channel state, config registers, scaler
    sbcd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_req_type  (i_s_axis_tuser),
        .i_rx_byte   (i_s_axis_tdata),
        .i_frame_end (i_s_axis_tlast),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_value     (w_value)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = {4'd0, w_value};
    // channel index of the pending result is the controller's channel counter
    assign o_m_axis_tuser = w_cmd.ch_sel;

endmodule

// ----- hdl/sbcd_checker.sv -----
// ---------------------------------------------------------------------------
// sbcd_checker
// port-level checks of the sbus decoder, bound to the top level
// ---------------------------------------------------------------------------
`include "sbus_channel_decode_calibrate_defines.svh"

module sbcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // a stalled result holds
    `SBCD_ASSERT_NEXT(a_res_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
    // no request intake while a result is pending
    `SBCD_ASSERT_SAME(a_busy_out, o_m_axis_tvalid, !o_s_axis_tready)
    // last result belongs to the final channel
    `SBCD_ASSERT_SAME(a_last_ch, o_m_axis_tvalid && o_m_axis_tlast, o_m_axis_tuser == 3'd7)
    // no result straight after a request
    `SBCD_ASSERT_NEXT(a_no_early, i_s_axis_tvalid && o_s_axis_tready, !o_m_axis_tvalid)
    // still busy after a result that is not the last
    `SBCD_ASSERT_NEXT(a_tick_busy, o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast, !o_s_axis_tready)

endmodule

bind sbus_channel_decode_calibrate sbcd_checker u_sbcd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ----- tb/sv/tb_sbus_channel_decode_calibrate.sv -----
// ---------------------------------------------------------------------------
// tb_sbus_channel_decode_calibrate
// drives sbus bytes, ticks and calibration requests into the decoder and
// checks every scaled channel result against a behavioral predictor
// ---------------------------------------------------------------------------

// scoreboard: holds the predictor state and the queue of expected channel results
class sbus_scale_board;
    logic [11:0] out_min_r, out_max_r;
    logic [10:0] thr_r;
    logic        save_r;
    logic [7:0]  fbuf [sbcd_pkg::FRAME_BYTES];
    int          nbytes;
    logic [10:0] chv [sbcd_pkg::NUM_CH];
    logic [10:0] chlo [sbcd_pkg::NUM_CH];
    logic [10:0] chhi [sbcd_pkg::NUM_CH];
    bit          linked, cal_mode;
    logic [15:0] want_q [$];   // {last, idx, value}
    int          errors;

    function new();
        out_min_r = sbcd_pkg::OUT_MIN_RST;
        out_max_r = sbcd_pkg::OUT_MAX_RST;
        thr_r = sbcd_pkg::THR_RST;
        save_r = 0;
        nbytes = 0; linked = 0; cal_mode = 0; errors = 0;
        for (int k = 0; k < sbcd_pkg::NUM_CH; k++) begin
            chv[k] = 0; chlo[k] = sbcd_pkg::LOW_RESET; chhi[k] = sbcd_pkg::HIGH_RESET;
        end
    endfunction

    function void write_reg(logic [1:0] idx, logic [11:0] d);
        case (idx)
            sbcd_pkg::REG_OUT_MIN: out_min_r = d;
            sbcd_pkg::REG_OUT_MAX: out_max_r = d;
            sbcd_pkg::REG_THR:     thr_r = d[10:0];
            sbcd_pkg::REG_SAVE:    save_r = d[0];
        endcase
    endfunction

    function logic [10:0] unpack(int k);
        logic [10:0] acc;
        int p;
        acc = 0;
        for (int b = 0; b < 11; b++) begin
            p = 8 + 11 * k + b;
            if ((p >> 3) < sbcd_pkg::FRAME_BYTES) acc[b] = fbuf[p >> 3][p & 7];
        end
        return acc;
    endfunction

    function logic [11:0] scale(logic [10:0] v, logic [10:0] lo, logic [10:0] hi);
        longint d, t;
        if (hi <= lo) return out_min_r;
        d = longint'(hi) - longint'(lo);
        t = longint'(out_min_r) * d + (longint'(v) - longint'(lo)) *
            (longint'(out_max_r) - longint'(out_min_r));
        t = t / d;
        if (t > longint'(out_max_r)) t = out_max_r;
        if (t < longint'(out_min_r)) t = out_min_r;
        return t[11:0];
    endfunction

    // note an accepted request and queue what it should produce
    function void note_request(logic [1:0] kind, logic [7:0] b, logic fend);
        if (kind == sbcd_pkg::REQ_BYTE) begin
            if (nbytes < sbcd_pkg::FRAME_BYTES) begin
                fbuf[nbytes] = b; nbytes++;
            end else nbytes = sbcd_pkg::FRAME_BYTES + 1;
            if (fend) begin
                if (nbytes == sbcd_pkg::FRAME_BYTES) begin
                    for (int k = 0; k < sbcd_pkg::NUM_CH; k++) chv[k] = unpack(k);
                    linked = (chv[0] > thr_r) && (chv[1] > thr_r);
                end
                nbytes = 0;
            end
        end else if (kind == sbcd_pkg::REQ_CAL) begin
            cal_mode = 1;
        end else if (kind == sbcd_pkg::REQ_TICK && linked) begin
            if (cal_mode) begin
                for (int k = 0; k < sbcd_pkg::NUM_CH; k++) begin
                    if (chv[k] < chlo[k]) chlo[k] = chv[k];
                    if (chv[k] > chhi[k]) chhi[k] = chv[k];
                end
                if (save_r) cal_mode = 0;
            end else begin
                for (int k = 0; k < sbcd_pkg::NUM_CH; k++)
                    want_q.push_back({(k == sbcd_pkg::NUM_CH - 1) ? 1'b1 : 1'b0, 3'(k),
                                      scale(chv[k], chlo[k], chhi[k])});
            end
        end
    endfunction

    function void check_result(logic [15:0] data, logic [2:0] idx, logic lst);
        logic [15:0] w;
        if (want_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result idx=%0d val=%0d", idx, data);
            return;
        end
        w = want_q.pop_front();
        if (data !== {4'd0, w[11:0]} || idx !== w[14:12] || lst !== w[15]) begin
            errors++;
            if (errors <= 10)
                $display("mismatch exp idx=%0d val=%0d last=%0d got idx=%0d val=%0d last=%0d",
                         w[14:12], w[11:0], w[15], idx, data, lst);
        end
    endfunction
endclass

module tb_sbus_channel_decode_calibrate;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_axis_tvalid = 0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 0;
    logic [1:0]  i_s_axis_tuser = 0;
    logic        i_s_axis_tlast = 0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 0;
    logic [15:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 0;
    logic [11:0] i_cfg_data = 0;

    sbus_scale_board board = new();
    int  cycles = 0;
    int  sent = 0;          // accepted requests so far
    bit  hold_off = 0;      // long receiver stall requested by stimulus
    bit  quiet_sink = 0;    // stretch with no receiver idling

    localparam int LIMIT = 3000000;
    localparam int ITEMS = 130;

    sbus_channel_decode_calibrate dut (.*);

    always #6 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_sbus_channel_decode_calibrate: FAIL");
            $finish;
        end
    end

    // receiver: random ready gaps, checks each accepted result
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = quiet_sink ? 0 : $urandom_range(0, 13);
            if (gap > 0 || hold_off) begin
                i_m_axis_tready <= 0;
                repeat (gap) @(posedge i_clk);
                while (hold_off) @(posedge i_clk);
            end
            i_m_axis_tready <= 1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            board.check_result(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
        end
    end

    // one request with an optional random leading gap; valid stays up until the next step
    task automatic send_req(logic [1:0] kind, logic [7:0] b, logic fend, bit gaps = 1);
        int gap;
        gap = gaps ? $urandom_range(0, 13) : 0;
        i_cfg_valid <= 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= fend;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        board.note_request(kind, b, fend);
        sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] d);
        i_s_axis_tvalid <= 0;
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, d);
    endtask

    // wait until all results are back plus a little slack
    task automatic drain();
        i_s_axis_tvalid <= 0;
        i_cfg_valid <= 0;
        while (board.want_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // full 25-byte frame carrying the given first two channels, rest random
    task automatic send_frame(logic [10:0] c0, logic [10:0] c1, bit gaps);
        logic [7:0] fb [sbcd_pkg::FRAME_BYTES];
        logic [21:0] head;
        for (int i = 0; i < sbcd_pkg::FRAME_BYTES; i++) fb[i] = 8'($urandom_range(0, 255));
        head = {c1, c0};
        fb[1] = head[7:0]; fb[2] = head[15:8];
        fb[3][5:0] = head[21:16];
        for (int i = 0; i < sbcd_pkg::FRAME_BYTES; i++)
            send_req(sbcd_pkg::REQ_BYTE, fb[i], i == sbcd_pkg::FRAME_BYTES - 1, gaps);
    endtask

    task automatic rand_phase(int n);
        int r;
        for (int i = 0; i < n && sent < ITEMS; i++) begin
            r = $urandom_range(0, 9);
            if (r < 5) send_frame(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                                  $urandom_range(0, 3) == 0);
            else if (r < 8) send_req(sbcd_pkg::REQ_TICK, 8'($urandom), 1'($urandom));
            else if (r == 8) send_req(sbcd_pkg::REQ_CAL, 8'($urandom), 1'($urandom));
            else if ($urandom_range(0, 1)) send_req(2'd3, 8'($urandom), 1'($urandom));
            else begin
                // broken burst: short or overlong
                r = $urandom_range(0, 1) ? $urandom_range(1, 24) : $urandom_range(26, 30);
                for (int j = 0; j < r; j++)
                    send_req(sbcd_pkg::REQ_BYTE, 8'($urandom), j == r - 1, 0);
            end
        end
    endtask

    initial begin
        int ph;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: not connected tick, short and overlong bursts
        send_req(sbcd_pkg::REQ_TICK, 8'hff, 1);
        for (int j = 0; j < 3; j++) send_req(sbcd_pkg::REQ_BYTE, 8'h00, j == 2, 0);
        send_frame(11'd2047, 11'd2047, 0);
        send_req(sbcd_pkg::REQ_TICK, 8'h00, 0);
        for (int j = 0; j < 26; j++) send_req(sbcd_pkg::REQ_BYTE, 8'hff, j == 25, 0);
        send_req(sbcd_pkg::REQ_TICK, 8'h00, 0);
        send_req(2'd3, 8'hff, 1);
        send_req(sbcd_pkg::REQ_CAL, 8'h00, 0);
        send_req(sbcd_pkg::REQ_TICK, 8'h00, 0);  // calibration tick, stays in mode
        send_req(sbcd_pkg::REQ_TICK, 8'h00, 0);
        drain();

        write_reg(sbcd_pkg::REG_SAVE, 12'd1);
        send_req(sbcd_pkg::REQ_TICK, 8'h00, 0);  // ends calibration
        send_req(sbcd_pkg::REQ_TICK, 8'h00, 0);

        // pressure: long receiver stall while ticks keep coming
        hold_off = 1;
        fork
            begin repeat (2000) @(posedge i_clk); hold_off = 0; end
            for (int j = 0; j < 3; j++) send_req(sbcd_pkg::REQ_TICK, 8'h00, 0, 0);
        join
        drain();

        // inverted range, then max threshold disconnects
        write_reg(sbcd_pkg::REG_OUT_MIN, 12'd4095);
        write_reg(sbcd_pkg::REG_OUT_MAX, 12'd0);
        send_req(sbcd_pkg::REQ_TICK, 8'h00, 0);
        drain();
        write_reg(sbcd_pkg::REG_THR, 12'd2047);
        send_frame(11'd2047, 11'd2047, 0);
        send_req(sbcd_pkg::REQ_TICK, 8'h00, 0);
        drain();

        // random phases until the request budget is spent
        ph = 0;
        while (sent < ITEMS) begin
            if (ph == 0) begin
                write_reg(sbcd_pkg::REG_OUT_MIN, 12'd0);
                write_reg(sbcd_pkg::REG_OUT_MAX, 12'd4095);
                write_reg(sbcd_pkg::REG_THR, 12'd0);
                write_reg(sbcd_pkg::REG_SAVE, 12'd0);
                quiet_sink = 1;
            end else begin
                write_reg(sbcd_pkg::REG_OUT_MIN, 12'($urandom_range(0, 4095)));
                write_reg(sbcd_pkg::REG_OUT_MAX, 12'($urandom_range(0, 4095)));
                write_reg(sbcd_pkg::REG_THR, 12'($urandom_range(0, 1500)));
                write_reg(sbcd_pkg::REG_SAVE, 12'($urandom_range(0, 1)));
            end
            rand_phase(4);
            quiet_sink = 0;
            drain();
            ph++;
        end

        if (board.errors == 0 && board.want_q.size() == 0) begin
            $display("tb_sbus_channel_decode_calibrate: PASS");
        end else begin
            $display("tb_sbus_channel_decode_calibrate: FAIL");
        end
        $finish;
    end
endmodule
